// ===== src/scp_pkg.sv =====
// Shared types and constants for the servo command string parser.
// No dependencies; imported by the front, queue, back and top-level modules.
package scp_pkg;

  localparam int unsigned HDR_LEN    = 13;
  localparam int unsigned HDR_STORED = 12;
  localparam logic [3:0]  STOP_POS   = 4'd8;
  localparam logic [3:0]  BIAS_POS   = 4'd12;
  localparam logic [3:0]  POS_SAT    = 4'd13;

  // 48 * 111: offset of three ASCII digits weighted 100/10/1
  localparam logic [15:0] DIGIT3_BIAS = 16'd5328;
  localparam logic [15:0] BIAS_MAX    = 16'd200;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_HASH  = 8'h23;
  localparam logic [7:0] CHR_P     = 8'h50;
  localparam logic [7:0] CHR_T     = 8'h54;
  localparam logic [7:0] CHR_S     = 8'h53;
  localparam logic [7:0] CHR_C     = 8'h43;
  localparam logic [7:0] CHR_K     = 8'h4B;
  localparam logic [7:0] CHR_D     = 8'h44;
  localparam logic [7:0] CHR_BANG  = 8'h21;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    CH_OTHER,
    CH_NUL,
    CH_HASH,
    CH_P,
    CH_T,
    CH_BANG
  } char_kind_e;

  typedef enum logic [1:0] {
    CMD_MOVE = 2'd0,
    CMD_BIAS = 2'd1,
    CMD_STOP = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
    logic       is_digit;
    logic [3:0] digit;
    char_kind_e kind;
  } token_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [15:0]        servo_index;
    logic [13:0]        pulse_width;
    logic [13:0]        move_time;
    logic signed [13:0] bias_value;
  } command_t;

endpackage

// ===== src/scp_front.sv =====
// Front end: accepts stream bytes and classifies each into a parse token.
// Depends on scp_pkg; feeds scp_queue.
module scp_front
  import scp_pkg::*;
(
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,
  input  logic       s_axis_tlast_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output token_t     token_o
);

  function automatic char_kind_e classify(input logic [7:0] c);
    char_kind_e k;
    case (c)
      CHR_NUL:  k = CH_NUL;
      CHR_HASH: k = CH_HASH;
      CHR_P:    k = CH_P;
      CHR_T:    k = CH_T;
      CHR_BANG: k = CH_BANG;
      default:  k = CH_OTHER;
    endcase
    return k;
  endfunction

  logic [7:0] digit_full;

  assign s_axis_tready_o = !queue_full_i;
  assign push_o          = s_axis_tvalid_i && !queue_full_i;
  assign digit_full      = s_axis_tdata_i - CHR_ZERO;

  always_comb begin
    token_o.char_byte = s_axis_tdata_i;
    token_o.last      = s_axis_tlast_i;
    token_o.is_digit  = (s_axis_tdata_i >= CHR_ZERO) && (s_axis_tdata_i <= CHR_NINE);
    token_o.digit     = digit_full[3:0];
    token_o.kind      = classify(s_axis_tdata_i);
  end

endmodule

// ===== src/scp_queue.sv =====
// Token queue between the front end and the parser back end.
// Depends on scp_pkg for the token type.
module scp_queue
  import scp_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t token_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   head_valid_o,
  output token_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  token_t            slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign full_o       = (count_q == CNT_FULL);
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= token_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL) else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");
`endif

endmodule

// ===== src/scp_back.sv =====
// Back end: field parser, header capture, command decode and output register.
// Depends on scp_pkg; consumes tokens from scp_queue.
module scp_back
  import scp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] servo_limit_i,
  input  logic       head_valid_i,
  input  token_t     head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output command_t   out_cmd_o
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_INDEX,
    MODE_PULSE,
    MODE_TIME
  } mode_e;

  mode_e        mode_q, mode_d;
  logic [3:0]   pos_q, pos_d;
  logic [2:0]   cnt_q, cnt_d;
  logic [15:0]  index_q, index_d;
  logic [13:0]  pulse_q, pulse_d;
  logic [13:0]  time_q, time_d;
  logic         halted_q, halted_d;
  logic         out_valid_q, out_valid_d;
  command_t     out_cmd_q, out_cmd_d;

  logic [7:0]   hdr_q [HDR_STORED];
  logic         hdr_we;

  logic         pop;
  logic         emit;
  logic         stop_hit;
  logic         bias_form;
  logic [15:0]  hdr_index;
  logic [15:0]  mag_sum;
  logic [2:0]   cnt_inc;

  assign pop         = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_cmd_o   = out_cmd_q;
  assign cnt_inc     = cnt_q + 3'd1;

  assign hdr_index = 16'(hdr_q[1]) * 16'd100 + 16'(hdr_q[2]) * 16'd10
                   + 16'(hdr_q[3]) - DIGIT3_BIAS;
  assign mag_sum   = 16'(hdr_q[9]) * 16'd100 + 16'(hdr_q[10]) * 16'd10
                   + 16'(hdr_q[11]);

  assign stop_hit = (pos_q == STOP_POS) && (head_i.kind == CH_BANG)
                 && (hdr_q[0] == CHR_HASH) && (hdr_q[4] == CHR_P)
                 && (hdr_q[5] == CHR_D) && (hdr_q[6] == CHR_S)
                 && (hdr_q[7] == CHR_T);
  assign bias_form = (pos_q == BIAS_POS) && (head_i.kind == CH_BANG)
                  && (hdr_q[0] == CHR_HASH) && (hdr_q[4] == CHR_P)
                  && (hdr_q[5] == CHR_S) && (hdr_q[6] == CHR_C)
                  && (hdr_q[7] == CHR_K)
                  && (mag_sum <= DIGIT3_BIAS + BIAS_MAX)
                  && (hdr_index < {8'd0, servo_limit_i});

  always_comb begin
    mode_d      = mode_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    index_d     = index_q;
    pulse_d     = pulse_q;
    time_d      = time_q;
    halted_d    = halted_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_cmd_d   = out_cmd_q;
    hdr_we      = 1'b0;
    emit        = 1'b0;

    if (pop) begin
      if (!halted_q) begin
        if (head_i.kind == CH_NUL) begin
          halted_d = 1'b1;
        end else begin
          hdr_we = (pos_q < 4'(HDR_STORED));
          if (pos_q != POS_SAT) begin
            pos_d = pos_q + 4'd1;
          end
          if (stop_hit) begin
            emit                  = 1'b1;
            halted_d              = 1'b1;
            out_cmd_d.kind        = CMD_STOP;
            out_cmd_d.servo_index = hdr_index;
            out_cmd_d.pulse_width = '0;
            out_cmd_d.move_time   = '0;
            out_cmd_d.bias_value  = '0;
          end else begin
            if (bias_form && (hdr_q[8] == CHR_PLUS || hdr_q[8] == CHR_MINUS)) begin
              emit                  = 1'b1;
              out_cmd_d.kind        = CMD_BIAS;
              out_cmd_d.servo_index = hdr_index;
              out_cmd_d.pulse_width = '0;
              out_cmd_d.move_time   = '0;
              out_cmd_d.bias_value  = (hdr_q[8] == CHR_PLUS)
                                    ? 14'(mag_sum - DIGIT3_BIAS)
                                    : 14'(DIGIT3_BIAS - mag_sum);
            end
            case (mode_q)
              MODE_IDLE: begin
                case (head_i.kind)
                  CH_HASH: begin
                    mode_d  = MODE_INDEX;
                    index_d = '0;
                    cnt_d   = '0;
                  end
                  CH_P: begin
                    mode_d  = MODE_PULSE;
                    pulse_d = '0;
                    cnt_d   = '0;
                  end
                  CH_T: begin
                    mode_d = MODE_TIME;
                    time_d = '0;
                    cnt_d  = '0;
                  end
                  default: ;
                endcase
              end
              default: begin
                if (!head_i.is_digit) begin
                  mode_d = MODE_IDLE;
                  cnt_d  = '0;
                end else begin
                  cnt_d = cnt_inc;
                  case (mode_q)
                    MODE_INDEX: begin
                      index_d = index_q * 16'd10 + 16'(head_i.digit);
                      if (cnt_inc >= 3'd3) begin
                        mode_d = MODE_IDLE;
                        cnt_d  = '0;
                      end
                    end
                    MODE_PULSE: begin
                      pulse_d = pulse_q * 14'd10 + 14'(head_i.digit);
                      if (cnt_inc >= 3'd4) begin
                        mode_d = MODE_IDLE;
                        cnt_d  = '0;
                      end
                    end
                    default: begin
                      time_d = time_q * 14'd10 + 14'(head_i.digit);
                      if (cnt_inc >= 3'd4) begin
                        mode_d = MODE_IDLE;
                        cnt_d  = '0;
                        if (!emit) begin
                          emit                  = 1'b1;
                          out_cmd_d.kind        = CMD_MOVE;
                          out_cmd_d.servo_index = index_q;
                          out_cmd_d.pulse_width = pulse_q;
                          out_cmd_d.move_time   = time_d;
                          out_cmd_d.bias_value  = '0;
                        end
                      end
                    end
                  endcase
                end
              end
            endcase
          end
        end
      end
      if (head_i.last) begin
        mode_d   = MODE_IDLE;
        pos_d    = '0;
        cnt_d    = '0;
        index_d  = '0;
        pulse_d  = '0;
        time_d   = '0;
        halted_d = 1'b0;
      end
      if (emit) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      pos_q       <= '0;
      cnt_q       <= '0;
      index_q     <= '0;
      pulse_q     <= '0;
      time_q      <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_cmd_q   <= '0;
    end else begin
      mode_q      <= mode_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      index_q     <= index_d;
      pulse_q     <= pulse_d;
      time_q      <= time_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
      out_cmd_q   <= out_cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[pos_q[3:0]] <= head_i.char_byte;
    end
  end

`ifndef SYNTH
  a_idle_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IDLE |-> cnt_q == '0) else $error("digit count left in idle");
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_SAT) else $error("byte position past saturation");
  a_stop_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && emit && out_cmd_d.kind == CMD_STOP && !head_i.last |=> halted_q)
    else $error("stop did not halt parsing");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && head_i.last |=> pos_q == '0 && !halted_q && mode_q == MODE_IDLE)
    else $error("string state not cleared after last byte");
`endif

endmodule

// ===== src/servo_command_string_parser_top.sv =====
// Top level of the servo command string parser: config register, front end,
// token queue and back end. Depends on scp_pkg, scp_front, scp_queue, scp_back.
//
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid/tready      tdata[7:0] char_byte, tlast end_of_string
// m_axis    out  tvalid/tready      tuser[1:0] command_kind, tdata see port
// apb       in   psel/penable       servo_limit at byte address 0
//
// One byte per cycle while the queue is not full; each accepted byte is
// held in the token queue, and the back end pops it and writes any command
// it completes into its output register.
// Output stalls are absorbed by the QUEUE_DEPTH token queue; tready drops
// only when that queue is full.
// Reset is asynchronous: servo_limit returns to 32, all parse state but the
// header and queue storage clears, and no clearing pass is needed.
module servo_command_string_parser_top
  import scp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] servo_index, [29:16] pulse_width, [43:30] move_time,
  // [57:44] bias_value, [63:58] zero
  output logic [63:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // [1:0] command_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [7:0] SERVO_LIMIT_RST = 8'd32;

  logic [7:0] servo_limit_q;
  logic       push;
  logic       queue_full;
  logic       pop;
  logic       head_valid;
  token_t     front_token;
  token_t     head_token;
  command_t   out_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, servo_limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_limit_q <= SERVO_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      servo_limit_q <= pwdata[7:0];
    end
  end

  scp_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .token_o         (front_token)
  );

  scp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .token_i      (front_token),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_token)
  );

  scp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .servo_limit_i (servo_limit_q),
    .head_valid_i  (head_valid),
    .head_i        (head_token),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_cmd_o     (out_cmd)
  );

  assign m_axis_tuser_o = out_cmd.kind;
  assign m_axis_tdata_o = {6'd0, out_cmd.bias_value, out_cmd.move_time,
                           out_cmd.pulse_width, out_cmd.servo_index};

endmodule
